[sv/tcr_pkg.sv]
// shared types and constants for the tick catch-up reconciler
package tcr_pkg;

   localparam int TIME_W    = 32;
   localparam int PERIOD_W  = 24;
   localparam int CATCHUP_W = 8;
   localparam int PATH_W    = 2;
   localparam int CSR_IDX_W = 1;
   localparam int DIV_STEPS = TIME_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CATCHUP = 1'b1;

   localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = 24'd10000;
   localparam logic [CATCHUP_W-1:0] CATCHUP_RESET = 8'd100;

   localparam logic [PATH_W-1:0] PATH_SEED    = 2'd0;
   localparam logic [PATH_W-1:0] PATH_NORMAL  = 2'd1;
   localparam logic [PATH_W-1:0] PATH_CAPPED  = 2'd2;
   localparam logic [PATH_W-1:0] PATH_EARLY   = 2'd3;

   typedef struct packed {
      logic load;    // capture beat, start elapsed / period
      logic step;    // one restoring divide step
      logic finish;  // update state and load result register
   } tcr_cmd_type;

   typedef struct packed {
      logic seeded;
   } tcr_status_type;

endpackage

[sv/tcr_ctrl.sv]
// controller: handshake, divide step counter and sequencing
module tcr_ctrl
   import tcr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  tcr_status_type status,
   output tcr_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               // first beat needs no divide
               state_in = status.seeded ? ST_DIV : ST_DONE;
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[sv/tcr_dp.sv]
// datapath: config registers, tick state, serial divider and result register
module tcr_dp
   import tcr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PERIOD_W-1:0]  csr_data,
   input  logic [TIME_W-1:0]    req_now_us,
   input  tcr_cmd_type          cmd,
   output tcr_status_type       status,
   output logic [TIME_W-1:0]    rsp_tick_count,
   output logic [CATCHUP_W-1:0] rsp_ticks_added,
   output logic [PATH_W-1:0]    rsp_path_taken
);

   logic [PERIOD_W-1:0]  period_ff;
   logic [CATCHUP_W-1:0] catchup_ff;
   logic [TIME_W-1:0]    tick_ff, tick_in;
   logic [TIME_W-1:0]    ref_ff, ref_in;
   logic                 seeded_ff;
   logic [TIME_W-1:0]    now_ff;
   logic [TIME_W-1:0]    quo_ff;
   logic [PERIOD_W-1:0]  rem_ff;
   logic [TIME_W-1:0]    cnt_out_ff;
   logic [CATCHUP_W-1:0] add_out_ff, add_in;
   logic [PATH_W-1:0]    path_out_ff, path_in;

   logic [PERIOD_W-1:0]  per;
   logic [PERIOD_W:0]    shifted;
   logic [PERIOD_W:0]    diff;
   logic                 fits;

   // zero period behaves as one
   assign per     = (period_ff == '0) ? PERIOD_W'(1) : period_ff;
   assign shifted = {rem_ff, quo_ff[TIME_W-1]};
   assign diff    = shifted - {1'b0, per};
   assign fits    = (shifted >= {1'b0, per});

   assign status.seeded = seeded_ff;

   always_comb begin
      ref_in  = now_ff;
      add_in  = CATCHUP_W'(1);
      path_in = PATH_SEED;
      if (seeded_ff) begin
         if (quo_ff == '0) begin
            path_in = PATH_EARLY;
         end else if (quo_ff > {{(TIME_W-CATCHUP_W){1'b0}}, catchup_ff}) begin
            add_in  = catchup_ff;
            path_in = PATH_CAPPED;
         end else begin
            // ref + n*per == now - remainder
            add_in  = quo_ff[CATCHUP_W-1:0];
            ref_in  = now_ff - {{(TIME_W-PERIOD_W){1'b0}}, rem_ff};
            path_in = PATH_NORMAL;
         end
      end
      tick_in = tick_ff + {{(TIME_W-CATCHUP_W){1'b0}}, add_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= PERIOD_RESET;
         catchup_ff <= CATCHUP_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PERIOD:  period_ff  <= csr_data;
            CSR_CATCHUP: catchup_ff <= csr_data[CATCHUP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         ref_ff    <= '0;
         seeded_ff <= 1'b0;
      end else if (cmd.finish) begin
         tick_ff   <= tick_in;
         ref_ff    <= ref_in;
         seeded_ff <= 1'b1;
      end
   end

   // restoring divider: quo_ff starts as elapsed, shifts out dividend bits
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff <= req_now_us;
         quo_ff <= req_now_us - ref_ff;
         rem_ff <= '0;
      end else if (cmd.step) begin
         quo_ff <= {quo_ff[TIME_W-2:0], fits};
         rem_ff <= fits ? diff[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         cnt_out_ff  <= tick_in;
         add_out_ff  <= add_in;
         path_out_ff <= path_in;
      end
   end

   assign rsp_tick_count  = cnt_out_ff;
   assign rsp_ticks_added = add_out_ff;
   assign rsp_path_taken  = path_out_ff;

endmodule

[sv/tick_catchup_reconciler.sv]
// top level of the tick catch-up reconciler
//
//   port group   direction   carries
//   req_*        in          one tick event beat: now_us
//   rsp_*        out         one result beat: tick_count, ticks_added, path_taken
//   csr_*        in          register writes: period_us (0), max_catchup (1)
//
// a seeded beat runs the accept cycle, then 32 steps of the one-bit-per-cycle
// restoring divider for elapsed / period, then finish, which loads the result
// register that drives rsp
// the first beat after reset skips the divider and goes from accept to finish
// reset clears tick count, reference, seeded flag and restores register defaults
// a new beat is accepted while a result waits; finish holds until rsp is free
module tick_catchup_reconciler
   import tcr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [TIME_W-1:0]    req_now_us,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [TIME_W-1:0]    rsp_tick_count,
   output logic [CATCHUP_W-1:0] rsp_ticks_added,
   output logic [PATH_W-1:0]    rsp_path_taken,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PERIOD_W-1:0]  csr_data
);

   tcr_cmd_type    cmd;
   tcr_status_type status;

   tcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcr_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_now_us      (req_now_us),
      .cmd             (cmd),
      .status          (status),
      .rsp_tick_count  (rsp_tick_count),
      .rsp_ticks_added (rsp_ticks_added),
      .rsp_path_taken  (rsp_path_taken)
   );

endmodule
